>>> hdl/aose_pkg.sv
package aose_pkg;
	localparam int NodeSlotsDef   = 1024;
	localparam int KeyBitsDef     = 32;
	localparam int PayloadBitsDef = 32;
	localparam int CostBitsDef    = 16;

	typedef enum logic [2:0] {
		ST_INSTALLED = 3'd0,
		ST_REJECTED  = 3'd1,
		ST_UPDATED   = 3'd2,
		ST_RESTARTED = 3'd3,
		ST_POPPED    = 3'd4,
		ST_EMPTY     = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	localparam logic OP_PUT = 1'b0;
	localparam logic OP_POP = 1'b1;
endpackage

>>> hdl/astar_open_set_engine.sv
// Open-set engine: node table with its frontier marks in one synchronous memory.
// A put or a pop scans the N used slots, one memory read per cycle, then writes back and
// registers the result, which is held with out_valid until out_ready takes it.
// One transaction at a time: in_ready is low from the moment a transaction is taken until
// its result is taken. The scan of the used slots and the wait on out_ready set the rate.
// Reset (arst_n, asynchronous, active low) clears the counts; read data is used only from slots below them.
module astar_open_set_engine
	import aose_pkg::*;
#(
	parameter int NODE_SLOTS   = NodeSlotsDef,
	parameter int KEY_BITS     = KeyBitsDef,
	parameter int PAYLOAD_BITS = PayloadBitsDef,
	parameter int COST_BITS    = CostBitsDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    opcode,
	input  logic [KEY_BITS-1:0]     node_key,
	input  logic [PAYLOAD_BITS-1:0] node_payload,
	input  logic [COST_BITS-1:0]    cost_so_far,
	input  logic [COST_BITS-1:0]    cost_estimate,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              status,
	output logic [KEY_BITS-1:0]     out_key,
	output logic [PAYLOAD_BITS-1:0] out_payload,
	output logic [COST_BITS-1:0]    out_cost_so_far,
	output logic [COST_BITS-1:0]    out_cost_estimate
);
	localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int CW = $clog2(NODE_SLOTS + 1);

	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] pay;
		logic [COST_BITS-1:0]    g;
		logic [COST_BITS-1:0]    h;
		logic                    fr;   // in frontier
	} entry_t;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DONE, S_OUT} state_t;

	// node memory, one read port (registered), one write port
	entry_t mem [NODE_SLOTS];
	entry_t rd_q;
	logic   we;
	logic [IW-1:0] wa;
	entry_t wd;
	logic [IW-1:0] ra;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	logic [CW-1:0] ecount_q, hcount_q;
	state_t state_q;
	logic op_q;
	entry_t req_q;
	logic [CW-1:0] idx_q;        // next address issued
	logic rv_q;                  // read data valid for slot rs_q
	logic [IW-1:0] rs_q;
	logic found_q;
	logic [IW-1:0] best_q;
	logic [COST_BITS:0] bestf_q;
	entry_t best_e_q;

	logic [COST_BITS:0] rf, nf;
	assign rf = {1'b0, rd_q.g} + {1'b0, rd_q.h};
	assign nf = {1'b0, req_q.g} + {1'b0, req_q.h};
	assign ra = idx_q[IW-1:0];
	assign in_ready = (state_q == S_IDLE);

	// a rows' candidacy during the scan
	logic hit;
	always_comb begin
		if (op_q == OP_POP) hit = rv_q && rd_q.fr && (!found_q || rf < bestf_q);
		else hit = rv_q && !found_q && (rd_q.key == req_q.key);
	end

	// single write-back: pop clears the mark, update, restart and install write the new row
	always_comb begin
		we = 1'b0;
		wa = best_q;
		wd = req_q;
		if (state_q == S_DONE) begin
			if (op_q == OP_POP) begin
				we    = found_q;
				wd    = best_e_q;
				wd.fr = 1'b0;
			end else if (found_q) begin
				we = (bestf_q > nf);
			end else if (ecount_q < CW'(NODE_SLOTS)) begin
				we = 1'b1;
				wa = ecount_q[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ecount_q  <= '0;
			hcount_q  <= '0;
			out_valid <= 1'b0;
			rv_q      <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						req_q   <= '{node_key, node_payload, cost_so_far, cost_estimate, 1'b1};
						idx_q   <= '0;
						rv_q    <= 1'b0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q  <= 1'b1;
						best_q   <= rs_q;
						bestf_q  <= rf;
						best_e_q <= rd_q;
					end
					if (idx_q < ecount_q) begin
						rv_q  <= 1'b1;
						rs_q  <= idx_q[IW-1:0];
						idx_q <= idx_q + 1'b1;
					end else begin
						rv_q <= 1'b0;
						if (!rv_q) state_q <= S_DONE;
					end
				end
				S_DONE: begin
					out_key           <= req_q.key;
					out_payload       <= '0;
					out_cost_so_far   <= '0;
					out_cost_estimate <= '0;
					if (op_q == OP_POP) begin
						if (found_q) begin
							status            <= ST_POPPED;
							if (hcount_q != '0) hcount_q <= hcount_q - 1'b1;
							out_key           <= best_e_q.key;
							out_payload       <= best_e_q.pay;
							out_cost_so_far   <= best_e_q.g;
							out_cost_estimate <= best_e_q.h;
						end else begin
							status  <= ST_EMPTY;
							out_key <= '0;
						end
					end else if (found_q) begin
						if (bestf_q <= nf) status <= ST_REJECTED;
						else if (best_e_q.fr) status <= ST_UPDATED;
						else begin
							status   <= ST_RESTARTED;
							hcount_q <= hcount_q + 1'b1;
						end
					end else if (ecount_q >= CW'(NODE_SLOTS)) begin
						status <= ST_FULL;
					end else begin
						status   <= ST_INSTALLED;
						ecount_q <= ecount_q + 1'b1;
						hcount_q <= hcount_q + 1'b1;
					end
					out_valid <= 1'b1;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) hcount_q <= ecount_q)
		else $error("frontier larger than table");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("result outside output state");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_POPPED) |-> out_key == best_e_q.key)
		else $error("popped key mismatch");
endmodule
